/* src/stc_pkg.sv */
// Shared types, constants and tables for the seconds-to-calendar converter.
`default_nettype none

package stc_pkg;

    localparam int unsigned SEC_W = 32;

    // Day split: seconds divided by 86400 through a reciprocal multiply.
    localparam logic [16:0] SECS_PER_DAY = 17'd86400;
    localparam logic [16:0] BIAS_DAYS    = 17'd25567;
    localparam int unsigned DAY_SHIFT    = 48;
    localparam logic [31:0] DAY_RECIP    = 32'((64'd1 << DAY_SHIFT) / 64'd86400);

    // Year estimate: days divided by 365.
    localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
    localparam int unsigned YEAR_SHIFT    = 24;
    localparam logic [15:0] YEAR_RECIP    = 16'(((64'd1 << YEAR_SHIFT) + 64'd364) / 64'd365);

    // Hour and minute split.
    localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
    localparam int unsigned HOUR_SHIFT    = 29;
    localparam logic [17:0] HOUR_RECIP    = 18'(((64'd1 << HOUR_SHIFT) + 64'd3599) / 64'd3600);
    localparam logic [11:0] SECS_PER_MIN  = 12'd60;
    localparam int unsigned MIN_SHIFT     = 18;
    localparam logic [12:0] MIN_RECIP     = 13'(((64'd1 << MIN_SHIFT) + 64'd59) / 64'd60);

    // Weekday remainder by 7.
    localparam int unsigned WEEK_SHIFT = 17;
    localparam logic [14:0] WEEK_RECIP = 15'(((64'd1 << WEEK_SHIFT) + 64'd6) / 64'd7);

    localparam logic [11:0] YEAR_BASE    = 12'd1900;
    localparam logic [11:0] YEAR_2000    = 12'd2000;
    localparam logic [11:0] YEAR_2100    = 12'd2100;
    localparam logic [3:0]  MONTH_MARCH  = 4'd2;
    localparam int unsigned MONTHS       = 12;

    localparam logic [8:0] CUM_COMMON [MONTHS] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };
    localparam logic [8:0] CUM_LEAP [MONTHS] = '{
        9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
        9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335
    };

    // floor(31 * m / 12) of the congruence, indexed by zero-based month.
    localparam logic [4:0] MONTH_TERM [MONTHS] = '{
        5'd28, 5'd31, 5'd2, 5'd5, 5'd7, 5'd10,
        5'd12, 5'd15, 5'd18, 5'd20, 5'd23, 5'd25
    };

    typedef struct packed {
        logic [16:0] days;
        logic [16:0] rem;
    } t_split;

    typedef struct packed {
        logic [7:0]  yr;
        logic [3:0]  mon;
        logic [4:0]  dom;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [11:0] rem2;
    } t_date;

    typedef struct packed {
        logic [11:0] cal_year;
        logic [3:0]  cal_month;
        logic [4:0]  cal_day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  sec_of_min;
        logic [2:0]  weekday;
    } t_cal;

    // First day of a year counted from 1900, with every fourth year leap.
    function automatic logic [16:0] year_start(input logic [7:0] y);
        logic [16:0] base;
        base = 17'(y) * 17'(DAYS_PER_YEAR);
        if (y == 8'd0) begin
            return 17'd0;
        end
        return base + 17'((y - 8'd1) >> 2);
    endfunction

    function automatic logic [8:0] cum_days(input logic leap, input logic [3:0] mon);
        return leap ? CUM_LEAP[mon] : CUM_COMMON[mon];
    endfunction

endpackage

`default_nettype wire

/* src/stc_if.sv */
// Handshake channels for the seconds input and the calendar output.
`default_nettype none

interface stc_sec_if;
    logic                       valid;
    logic                       ready;
    logic [stc_pkg::SEC_W-1:0]  epoch_seconds;

    modport source(output valid, output epoch_seconds, input ready);
    modport sink(input valid, input epoch_seconds, output ready);
endinterface

interface stc_cal_if;
    logic        valid;
    logic        ready;
    logic [11:0] cal_year;
    logic [3:0]  cal_month;
    logic [4:0]  cal_day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  sec_of_min;
    logic [2:0]  weekday;

    modport source(output valid, output cal_year, output cal_month, output cal_day,
                   output hour, output minute, output sec_of_min, output weekday,
                   input ready);
    modport sink(input valid, input cal_year, input cal_month, input cal_day,
                 input hour, input minute, input sec_of_min, input weekday,
                 output ready);
endinterface

`default_nettype wire

/* src/seconds_to_calendar_core.sv */
// Top level of the seconds-to-calendar converter.
`default_nettype none

// Converts an unsigned 32-bit count of seconds since 1970-01-01 00:00:00 into
// year, month, day, hour, minute, second and weekday (0 is Sunday). Every year
// divisible by four counts as leap, including 2100, so dates from 2100-02-29 on
// run one day behind the Gregorian calendar. The converter is a nine-stage
// pipeline: it takes one beat per clock cycle unless the output stalls, and an
// accepted beat passes through every stage register before it leaves. The day
// split, the year and month search and the weekday remainder each take three
// stages, which sets that depth. A stalled output holds its beat while empty
// stages upstream keep filling, and nothing is dropped or repeated.
module seconds_to_calendar_core (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    stc_sec_if.sink    i_sec,
    stc_cal_if.source  o_cal
);

    logic            w_split_valid;
    logic            w_split_ready;
    stc_pkg::t_split w_split;
    logic            w_date_valid;
    logic            w_date_ready;
    stc_pkg::t_date  w_date;
    stc_pkg::t_cal   w_cal;

    stc_day_split u_split (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_sec.valid),
        .o_ready (i_sec.ready),
        .i_secs  (i_sec.epoch_seconds),
        .o_valid (w_split_valid),
        .i_ready (w_split_ready),
        .o_data  (w_split)
    );

    stc_date u_date (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_split_valid),
        .o_ready (w_split_ready),
        .i_data  (w_split),
        .o_valid (w_date_valid),
        .i_ready (w_date_ready),
        .o_data  (w_date)
    );

    stc_weekday u_weekday (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_date_valid),
        .o_ready (w_date_ready),
        .i_data  (w_date),
        .o_valid (o_cal.valid),
        .i_ready (o_cal.ready),
        .o_data  (w_cal)
    );

    assign o_cal.cal_year   = w_cal.cal_year;
    assign o_cal.cal_month  = w_cal.cal_month;
    assign o_cal.cal_day    = w_cal.cal_day;
    assign o_cal.hour       = w_cal.hour;
    assign o_cal.minute     = w_cal.minute;
    assign o_cal.sec_of_min = w_cal.sec_of_min;
    assign o_cal.weekday    = w_cal.weekday;

endmodule

`default_nettype wire

/* src/stc_day_split.sv */
// Three pipeline stages that split the seconds into a day count and seconds of day.
`default_nettype none

module stc_day_split (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic [stc_pkg::SEC_W-1:0] i_secs,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output stc_pkg::t_split                o_data
);

    logic        r_v1, r_v2, r_v3;
    logic        w_en1, w_en2, w_en3;

    logic [15:0] r1_q;
    logic [31:0] r1_secs;
    logic [15:0] r2_q;
    logic [31:0] r2_secs;
    logic [32:0] r2_prod;
    stc_pkg::t_split r3_data;

    logic [63:0] w_prod1;
    logic [15:0] n_q;
    logic [32:0] w_diff;
    logic [17:0] w_rem_raw;
    logic        w_wrap;
    stc_pkg::t_split n_data;

    assign w_en3   = !r_v3 || i_ready;
    assign w_en2   = !r_v2 || w_en3;
    assign w_en1   = !r_v1 || w_en2;
    assign o_ready = w_en1;
    assign o_valid = r_v3;
    assign o_data  = r3_data;

    // The reciprocal estimate is at most one below the true quotient.
    assign w_prod1 = 64'(i_secs) * 64'(stc_pkg::DAY_RECIP);
    assign n_q     = w_prod1[stc_pkg::DAY_SHIFT +: 16];

    always_comb begin
        w_diff      = {1'b0, r2_secs} - r2_prod;
        w_rem_raw   = w_diff[17:0];
        w_wrap      = w_rem_raw >= 18'(stc_pkg::SECS_PER_DAY);
        n_data.rem  = w_wrap ? 17'(w_rem_raw - 18'(stc_pkg::SECS_PER_DAY)) : w_rem_raw[16:0];
        n_data.days = 17'(r2_q) + 17'(w_wrap) + stc_pkg::BIAS_DAYS;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= i_valid;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1 && i_valid) begin
            r1_q    <= n_q;
            r1_secs <= i_secs;
        end
        if (w_en2 && r_v1) begin
            r2_q    <= r1_q;
            r2_secs <= r1_secs;
            r2_prod <= 33'(r1_q) * 33'(stc_pkg::SECS_PER_DAY);
        end
        if (w_en3 && r_v2) begin
            r3_data <= n_data;
        end
    end

endmodule

`default_nettype wire

/* src/stc_date.sv */
// Three pipeline stages that find year, month, day, hour and minute.
`default_nettype none

module stc_date (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire stc_pkg::t_split i_data,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output stc_pkg::t_date       o_data
);

    logic        r_v4, r_v5, r_v6;
    logic        w_en4, w_en5, w_en6;

    logic [7:0]  r4_yr;
    logic [4:0]  r4_hour;
    logic [16:0] r4_days;
    logic [16:0] r4_rem;

    logic [7:0]  r5_yr;
    logic [8:0]  r5_doy;
    logic [4:0]  r5_hour;
    logic [11:0] r5_rem2;

    stc_pkg::t_date r6_data;

    logic [32:0] w_yprod;
    logic [34:0] w_hprod;
    logic [7:0]  w_y1, w_y2;
    logic [16:0] w_s0, w_s1, w_s2;
    logic [7:0]  n_yr;
    logic [16:0] w_start;
    logic [16:0] w_hsecs;
    logic        w_leap;
    logic [3:0]  n_mon;
    logic [24:0] w_mprod;
    stc_pkg::t_date n_data;

    assign w_en6   = !r_v6 || i_ready;
    assign w_en5   = !r_v5 || w_en6;
    assign w_en4   = !r_v4 || w_en5;
    assign o_ready = w_en4;
    assign o_valid = r_v6;
    assign o_data  = r6_data;

    assign w_yprod = 33'(i_data.days) * 33'(stc_pkg::YEAR_RECIP);
    assign w_hprod = 35'(i_data.rem) * 35'(stc_pkg::HOUR_RECIP);

    // The estimate days/365 can overshoot the year; step back to the latest
    // candidate whose first day is not past the day count.
    always_comb begin
        w_y1 = r4_yr - 8'd1;
        w_y2 = r4_yr - 8'd2;
        w_s0 = stc_pkg::year_start(r4_yr);
        w_s1 = stc_pkg::year_start(w_y1);
        w_s2 = stc_pkg::year_start(w_y2);
        if (r4_days >= w_s0) begin
            n_yr    = r4_yr;
            w_start = w_s0;
        end else if (r4_days >= w_s1) begin
            n_yr    = w_y1;
            w_start = w_s1;
        end else begin
            n_yr    = w_y2;
            w_start = w_s2;
        end
        w_hsecs = 17'(r4_hour) * 17'(stc_pkg::SECS_PER_HOUR);
    end

    always_comb begin
        w_leap = (r5_yr[1:0] == 2'b00) && (r5_yr != 8'd0);
        n_mon  = 4'd0;
        for (int m = 1; m < stc_pkg::MONTHS; m++) begin
            if (r5_doy >= stc_pkg::cum_days(w_leap, 4'(m))) begin
                n_mon = 4'(m);
            end
        end
        w_mprod        = 25'(r5_rem2) * 25'(stc_pkg::MIN_RECIP);
        n_data.yr      = r5_yr;
        n_data.mon     = n_mon;
        n_data.dom     = 5'(r5_doy - stc_pkg::cum_days(w_leap, n_mon) + 9'd1);
        n_data.hour    = r5_hour;
        n_data.minute  = w_mprod[stc_pkg::MIN_SHIFT +: 6];
        n_data.rem2    = r5_rem2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            if (w_en4) r_v4 <= i_valid;
            if (w_en5) r_v5 <= r_v4;
            if (w_en6) r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en4 && i_valid) begin
            r4_yr   <= w_yprod[stc_pkg::YEAR_SHIFT +: 8];
            r4_hour <= w_hprod[stc_pkg::HOUR_SHIFT +: 5];
            r4_days <= i_data.days;
            r4_rem  <= i_data.rem;
        end
        if (w_en5 && r_v4) begin
            r5_yr   <= n_yr;
            r5_doy  <= 9'(r4_days - w_start);
            r5_hour <= r4_hour;
            r5_rem2 <= 12'(r4_rem - w_hsecs);
        end
        if (w_en6 && r_v5) begin
            r6_data <= n_data;
        end
    end

endmodule

`default_nettype wire

/* src/stc_weekday.sv */
// Three pipeline stages that finish the seconds field and derive the weekday.
`default_nettype none

module stc_weekday (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire stc_pkg::t_date  i_data,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output stc_pkg::t_cal        o_data
);

    logic        r_v7, r_v8, r_v9;
    logic        w_en7, w_en8, w_en9;

    stc_pkg::t_cal r7_cal;
    logic [11:0]   r7_wsum;
    stc_pkg::t_cal r8_cal;
    logic [11:0]   r8_wsum;
    logic [9:0]    r8_q7;
    stc_pkg::t_cal r9_cal;

    logic [11:0]   w_year;
    logic          w_early;
    logic [11:0]   w_y;
    logic [4:0]    w_y100;
    logic [4:0]    w_y400;
    logic [11:0]   n_wsum;
    stc_pkg::t_cal n_cal;
    logic [26:0]   w_wprod;
    logic [12:0]   w_wd;
    stc_pkg::t_cal n_out;

    assign w_en9   = !r_v9 || i_ready;
    assign w_en8   = !r_v8 || w_en9;
    assign w_en7   = !r_v7 || w_en8;
    assign o_ready = w_en7;
    assign o_valid = r_v9;
    assign o_data  = r9_cal;

    // Zeller-style congruence; January and February count as months of the
    // previous year. The constant 7000 of the sum is a multiple of 7 and drops out.
    always_comb begin
        w_year  = 12'(i_data.yr) + stc_pkg::YEAR_BASE;
        w_early = i_data.mon < stc_pkg::MONTH_MARCH;
        w_y     = w_year - 12'(w_early);
        if (w_y >= stc_pkg::YEAR_2100) begin
            w_y100 = 5'd21;
        end else if (w_y >= stc_pkg::YEAR_2000) begin
            w_y100 = 5'd20;
        end else begin
            w_y100 = 5'd19;
        end
        w_y400 = (w_y >= stc_pkg::YEAR_2000) ? 5'd5 : 5'd4;
        n_wsum = 12'(i_data.dom) + w_y + (w_y >> 2) + 12'(w_y400)
               + 12'(stc_pkg::MONTH_TERM[i_data.mon]) - 12'(w_y100);

        n_cal.cal_year   = w_year;
        n_cal.cal_month  = i_data.mon + 4'd1;
        n_cal.cal_day    = i_data.dom;
        n_cal.hour       = i_data.hour;
        n_cal.minute     = i_data.minute;
        n_cal.sec_of_min = 6'(i_data.rem2 - 12'(i_data.minute) * stc_pkg::SECS_PER_MIN);
        n_cal.weekday    = 3'd0;
    end

    assign w_wprod = 27'(r7_wsum) * 27'(stc_pkg::WEEK_RECIP);

    always_comb begin
        w_wd          = 13'(r8_wsum) - (13'({r8_q7, 3'b000}) - 13'(r8_q7));
        n_out         = r8_cal;
        n_out.weekday = w_wd[2:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v7 <= 1'b0;
            r_v8 <= 1'b0;
            r_v9 <= 1'b0;
        end else begin
            if (w_en7) r_v7 <= i_valid;
            if (w_en8) r_v8 <= r_v7;
            if (w_en9) r_v9 <= r_v8;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en7 && i_valid) begin
            r7_cal  <= n_cal;
            r7_wsum <= n_wsum;
        end
        if (w_en8 && r_v7) begin
            r8_cal  <= r7_cal;
            r8_wsum <= r7_wsum;
            r8_q7   <= w_wprod[stc_pkg::WEEK_SHIFT +: 10];
        end
        if (w_en9 && r_v8) begin
            r9_cal <= n_out;
        end
    end

endmodule

`default_nettype wire
